/* rtl/srg_pkg.sv */
`timescale 1ns / 1ps

package srg_pkg;

   // Default number of fraction bits of the Q format used by the step and scale registers.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Growth factor is held in unsigned Q8.24.
   localparam logic [31:0] GROWTH_ONE = 32'h0100_0000;
   // exp(0.0015) in Q8.24.
   localparam logic [31:0] EXP_STEP_Q24 = 32'd16802401;

   // Serial multiplier: a 32-bit multiplier operand consumed one 4-bit digit per cycle.
   localparam int MUL_WIDTH = 32;
   localparam int DIGIT_BITS = 4;
   localparam int MUL_STEPS = MUL_WIDTH / DIGIT_BITS;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_STEPS);

   typedef enum logic {
      OP_TICK       = 1'b0,
      OP_SET_TARGET = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_RAMP_ENABLE = 2'd0,
      REG_RAMP_MODE   = 2'd1,
      REG_RAMP_STEP   = 2'd2,
      REG_EXP_SCALE   = 2'd3
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_APPLY = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

/* rtl/setpoint_ramp_generator_top.sv */
`timescale 1ns / 1ps

// Setpoint ramp generator. Each request either stores a new target (operation 1) or advances
// the setpoint one tick toward the target (operation 0), and each request returns exactly one
// response carrying the resulting signed Q16.16 setpoint and a flag that is set when the
// setpoint equals the target. Linear mode moves by ramp_step per tick and clamps at the target.
// Exponential mode grows a Q8.24 factor by exp(0.0015) each tick and drives the setpoint to
// plus or minus exp_scale times that factor, saturated, clamping at the target and resetting
// the factor when it passes. A set-target request, a linear tick or a tick that is already at
// the target goes from acceptance straight to the state that loads the response register,
// which waits until that register is free; no new request is accepted before the load. An
// exponential tick that is not already at the target first makes two passes through one
// shared serial multiplier that consumes a 4-bit digit per cycle, each pass followed by a
// rounding state and an update state, and then goes to the response load in the same way.
// A new request is accepted while the previous response still waits in the output register,
// but that request can only finish once the output register is free, so a stalled response
// side adds its stall cycles to the next request. The registers sit on an APB-style port at
// byte addresses 0, 4, 8 and 12; writing 0 to ramp_enable also snaps the setpoint to the
// stored target. Configuration should be written only while no request is in flight.
module setpoint_ramp_generator_top #(
   parameter int FRAC_BITS = srg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [31:0] req_target_value,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_setpoint,
   output logic               rsp_at_target,
   // Configuration port.
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // One unit in the Q format of the step and scale registers; this is their reset value.
   localparam logic [30:0] UNIT_Q = 31'(1) << FRAC_BITS;

   // Configuration registers.
   logic        ramp_enable_ff, ramp_enable_in;
   logic        ramp_mode_ff, ramp_mode_in;
   logic [30:0] ramp_step_ff, ramp_step_in;
   logic [30:0] exp_scale_ff, exp_scale_in;

   // Architectural state.
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] setpoint_ff, setpoint_in;
   logic [31:0]        growth_ff, growth_in;

   // Sequencer and serial multiplier.
   srg_pkg::state_type              state_ff, state_in;
   logic                            phase_ff, phase_in;   // 0: growth update, 1: magnitude
   logic                            dir_up_ff, dir_up_in;
   logic [31:0]                     mul_a_ff, mul_a_in;
   logic [31:0]                     mul_b_ff, mul_b_in;
   logic [31:0]                     acc_hi_ff, acc_hi_in;
   logic [31:0]                     prod_lo_ff, prod_lo_in;
   logic [srg_pkg::MUL_CNT_WIDTH-1:0] mul_cnt_ff, mul_cnt_in;
   logic [39:0]                     rnd_ff, rnd_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_setpoint_ff, rsp_setpoint_in;
   logic               rsp_at_target_ff, rsp_at_target_in;

   // Combinational helpers.
   logic                      req_fire;
   logic                      csr_write;
   srg_pkg::reg_index_type    csr_index;
   logic [35:0]               mul_sum;
   logic signed [33:0]        sp_ext;
   logic signed [33:0]        tg_ext;
   logic signed [33:0]        step_ext;
   logic                      going_up;
   logic signed [33:0]        lin_value;
   logic                      lin_clamp;
   logic [31:0]               grown;
   logic [31:0]               mag_up;
   logic [31:0]               mag_dn;
   logic signed [33:0]        exp_value;
   logic                      exp_clamp;
   logic                      out_free;

   assign req_ready     = (state_ff == srg_pkg::ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_setpoint  = rsp_setpoint_ff;
   assign rsp_at_target = rsp_at_target_ff;
   assign csr_pready    = 1'b1;
   assign csr_write     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index     = srg_pkg::reg_index_type'(csr_paddr[3:2]);
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // One digit of the multiplier operand per cycle: partial product plus running high word.
   assign mul_sum = {4'b0000, acc_hi_ff}
                  + ({4'b0000, mul_a_ff} * {32'd0, mul_b_ff[srg_pkg::DIGIT_BITS-1:0]});

   // Linear move: both directions are formed, the direction picks one, then the target clamps.
   assign sp_ext    = {{2{setpoint_ff[31]}}, setpoint_ff};
   assign tg_ext    = {{2{target_ff[31]}}, target_ff};
   assign step_ext  = $signed({3'b000, ramp_step_ff});
   assign going_up  = (setpoint_ff < target_ff);
   assign lin_value = going_up ? (sp_ext + step_ext) : (sp_ext - step_ext);
   assign lin_clamp = going_up ? (lin_value > tg_ext) : (lin_value < tg_ext);

   // Rounded products saturate: the growth factor at all ones, the magnitude at the
   // largest value that the signed setpoint can take in each direction.
   assign grown  = (|rnd_ff[39:32]) ? 32'hFFFF_FFFF : rnd_ff[31:0];
   assign mag_up = (rnd_ff > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd_ff[31:0];
   assign mag_dn = (rnd_ff > 40'h00_8000_0000) ? 32'h8000_0000 : rnd_ff[31:0];
   assign exp_value = dir_up_ff ? $signed({2'b00, mag_up}) : -$signed({2'b00, mag_dn});
   assign exp_clamp = dir_up_ff ? (exp_value > tg_ext) : (exp_value < tg_ext);

   always_comb begin
      ramp_enable_in   = ramp_enable_ff;
      ramp_mode_in     = ramp_mode_ff;
      ramp_step_in     = ramp_step_ff;
      exp_scale_in     = exp_scale_ff;
      target_in        = target_ff;
      setpoint_in      = setpoint_ff;
      growth_in        = growth_ff;
      state_in         = state_ff;
      phase_in         = phase_ff;
      dir_up_in        = dir_up_ff;
      mul_a_in         = mul_a_ff;
      mul_b_in         = mul_b_ff;
      acc_hi_in        = acc_hi_ff;
      prod_lo_in       = prod_lo_ff;
      mul_cnt_in       = mul_cnt_ff;
      rnd_in           = rnd_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_setpoint_in  = rsp_setpoint_ff;
      rsp_at_target_in = rsp_at_target_ff;

      unique case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = srg_pkg::ST_DONE;
               if (srg_pkg::op_type'(req_operation) == srg_pkg::OP_SET_TARGET) begin
                  target_in = req_target_value;
                  if (!ramp_enable_ff) begin
                     setpoint_in = req_target_value;
                  end
               end else begin
                  // Linear mode keeps the growth factor at one.
                  if (!ramp_mode_ff) begin
                     growth_in = srg_pkg::GROWTH_ONE;
                  end
                  if (setpoint_ff != target_ff) begin
                     if (!ramp_mode_ff) begin
                        setpoint_in = lin_clamp ? target_ff : lin_value[31:0];
                     end else begin
                        // Exponential tick: first grow the factor by exp(0.0015).
                        dir_up_in  = going_up;
                        phase_in   = 1'b0;
                        mul_a_in   = growth_ff;
                        mul_b_in   = srg_pkg::EXP_STEP_Q24;
                        acc_hi_in  = '0;
                        mul_cnt_in = '0;
                        state_in   = srg_pkg::ST_MUL;
                     end
                  end
               end
            end
         end
         srg_pkg::ST_MUL: begin
            acc_hi_in  = mul_sum[35:srg_pkg::DIGIT_BITS];
            prod_lo_in = {mul_sum[srg_pkg::DIGIT_BITS-1:0], prod_lo_ff[31:srg_pkg::DIGIT_BITS]};
            mul_b_in   = mul_b_ff >> srg_pkg::DIGIT_BITS;
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == srg_pkg::MUL_CNT_WIDTH'(srg_pkg::MUL_STEPS - 1)) begin
               state_in = srg_pkg::ST_ROUND;
            end
         end
         srg_pkg::ST_ROUND: begin
            // Drop 24 fraction bits, rounding half up.
            rnd_in   = {acc_hi_ff, prod_lo_ff[31:24]} + {39'd0, prod_lo_ff[23]};
            state_in = srg_pkg::ST_APPLY;
         end
         srg_pkg::ST_APPLY: begin
            if (!phase_ff) begin
               growth_in  = grown;
               phase_in   = 1'b1;
               mul_a_in   = grown;
               mul_b_in   = {1'b0, exp_scale_ff};
               acc_hi_in  = '0;
               mul_cnt_in = '0;
               state_in   = srg_pkg::ST_MUL;
            end else begin
               setpoint_in = exp_clamp ? target_ff : exp_value[31:0];
               if (exp_clamp) begin
                  growth_in = srg_pkg::GROWTH_ONE;
               end
               state_in = srg_pkg::ST_DONE;
            end
         end
         srg_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_setpoint_in  = setpoint_ff;
               rsp_at_target_in = (setpoint_ff == target_ff);
               state_in         = srg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srg_pkg::ST_IDLE;
         end
      endcase

      // Register writes are to arrive only while no request is in flight; the block does not enforce this.
      if (csr_write) begin
         unique case (csr_index)
            srg_pkg::REG_RAMP_ENABLE: begin
               ramp_enable_in = csr_pwdata[0];
               if (!csr_pwdata[0]) begin
                  setpoint_in = target_ff;
               end
            end
            srg_pkg::REG_RAMP_MODE: begin
               ramp_mode_in = csr_pwdata[0];
            end
            srg_pkg::REG_RAMP_STEP: begin
               ramp_step_in = csr_pwdata[30:0];
            end
            srg_pkg::REG_EXP_SCALE: begin
               exp_scale_in = csr_pwdata[30:0];
            end
            default: begin
               ramp_mode_in = ramp_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         srg_pkg::REG_RAMP_ENABLE: csr_prdata = {31'd0, ramp_enable_ff};
         srg_pkg::REG_RAMP_MODE:   csr_prdata = {31'd0, ramp_mode_ff};
         srg_pkg::REG_RAMP_STEP:   csr_prdata = {1'b0, ramp_step_ff};
         srg_pkg::REG_EXP_SCALE:   csr_prdata = {1'b0, exp_scale_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_enable_ff <= 1'b1;
         ramp_mode_ff   <= 1'b0;
         ramp_step_ff   <= UNIT_Q;
         exp_scale_ff   <= UNIT_Q;
         target_ff      <= '0;
         setpoint_ff    <= '0;
         growth_ff      <= srg_pkg::GROWTH_ONE;
         state_ff       <= srg_pkg::ST_IDLE;
         phase_ff       <= 1'b0;
         dir_up_ff      <= 1'b0;
         mul_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ramp_enable_ff <= ramp_enable_in;
         ramp_mode_ff   <= ramp_mode_in;
         ramp_step_ff   <= ramp_step_in;
         exp_scale_ff   <= exp_scale_in;
         target_ff      <= target_in;
         setpoint_ff    <= setpoint_in;
         growth_ff      <= growth_in;
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         dir_up_ff      <= dir_up_in;
         mul_cnt_ff     <= mul_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      mul_a_ff         <= mul_a_in;
      mul_b_ff         <= mul_b_in;
      acc_hi_ff        <= acc_hi_in;
      prod_lo_ff       <= prod_lo_in;
      rnd_ff           <= rnd_in;
      rsp_setpoint_ff  <= rsp_setpoint_in;
      rsp_at_target_ff <= rsp_at_target_in;
   end

   // Every accepted request leaves the idle state for work or for the response load.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != srg_pkg::ST_IDLE)
      else $error("accepted request did not start processing");

   // A response is loaded from the current setpoint and flags equality with the target.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_DONE && out_free
      |=> rsp_valid_ff && rsp_setpoint_ff == $past(setpoint_ff)
          && rsp_at_target_ff == ($past(setpoint_ff) == $past(target_ff)))
      else $error("response does not match the setpoint state");

   // An exponential update lands on the side of zero given by the direction, or on the target.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_APPLY && phase_ff && dir_up_ff
      |=> !setpoint_ff[31] || setpoint_ff == target_ff)
      else $error("upward exponential setpoint went negative");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_APPLY && phase_ff && !dir_up_ff
      |=> setpoint_ff[31] || setpoint_ff == 32'sd0 || setpoint_ff == target_ff)
      else $error("downward exponential setpoint went positive");

   // The growth pass always hands over to the magnitude pass.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_APPLY && !phase_ff |=> state_ff == srg_pkg::ST_MUL && phase_ff)
      else $error("growth update did not start the magnitude product");

endmodule

/* verif/setpoint_ramp_generator_top_test.sv */
`timescale 1ns / 1ps

module setpoint_ramp_generator_top_test;

   // One expected response: the setpoint after the request and the at-target flag.
   typedef struct packed {
      logic signed [31:0] setpoint;
      logic               at_target;
   } ramp_result_type;

   // Receiver stall patterns. Each one holds for a random stretch of cycles.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_ALTERNATE,
      STALL_HEAVY
   } stall_kind_type;

   // The tracker keeps its own copy of the ramp state and registers. Every accepted request
   // advances that copy and queues the response the block must return for it.
   class ramp_tracker;
      bit                 enable_ramp;
      bit                 exp_mode;
      logic [30:0]        step_size;
      logic [30:0]        exp_gain;
      logic signed [31:0] target;
      logic signed [31:0] setpoint;
      logic [31:0]        growth;
      ramp_result_type    expected_results[$];
      int                 mismatches;

      function new();
         enable_ramp = 1'b1;
         exp_mode = 1'b0;
         step_size = 31'(1) << srg_pkg::FRAC_BITS_DEFAULT;
         exp_gain = 31'(1) << srg_pkg::FRAC_BITS_DEFAULT;
         target = '0;
         setpoint = '0;
         growth = srg_pkg::GROWTH_ONE;
         mismatches = 0;
      endfunction

      function void apply_register(srg_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            srg_pkg::REG_RAMP_ENABLE: begin
               enable_ramp = value[0];
               // Turning the ramp off lands the setpoint on the stored target at once.
               if (!enable_ramp)
                  setpoint = target;
            end
            srg_pkg::REG_RAMP_MODE: exp_mode = value[0];
            srg_pkg::REG_RAMP_STEP: step_size = value[30:0];
            srg_pkg::REG_EXP_SCALE: exp_gain = value[30:0];
         endcase
      endfunction

      // One tick of the ramp toward the target.
      function void advance_ramp();
         longint      here;
         longint      goal;
         longint      next;
         logic [63:0] prod;
         bit          rising;
         if (!exp_mode)
            growth = srg_pkg::GROWTH_ONE;
         if (setpoint == target)
            return;
         here = setpoint;
         goal = target;
         rising = here < goal;
         if (!exp_mode) begin
            next = rising ? here + longint'(step_size) : here - longint'(step_size);
         end else begin
            // Grow the Q8.24 factor with round half up, saturating at all ones.
            prod = (64'(growth) * 64'(srg_pkg::EXP_STEP_Q24) + 64'd8388608) >> 24;
            growth = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            // The magnitude is the scale times the factor, back in Q16.16.
            prod = (64'(exp_gain) * 64'(growth) + 64'd8388608) >> 24;
            if (rising) begin
               if (prod > 64'h7FFF_FFFF)
                  prod = 64'h7FFF_FFFF;
               next = longint'(prod);
            end else begin
               if (prod > 64'h8000_0000)
                  prod = 64'h8000_0000;
               next = -longint'(prod);
            end
         end
         // Only passing the target clamps; an exact hit keeps the growth.
         if (rising ? next > goal : next < goal) begin
            growth = srg_pkg::GROWTH_ONE;
            next = goal;
         end
         setpoint = next[31:0];
      endfunction

      function void note_request(srg_pkg::op_type op, logic signed [31:0] value);
         ramp_result_type outcome;
         if (op == srg_pkg::OP_SET_TARGET) begin
            target = value;
            if (!enable_ramp)
               setpoint = target;
         end else begin
            advance_ramp();
         end
         outcome.setpoint = setpoint;
         outcome.at_target = (setpoint == target);
         expected_results.push_back(outcome);
      endfunction

      function void check_response(logic signed [31:0] got_setpoint, logic got_at_target);
         ramp_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected response: setpoint %h, at_target %b", got_setpoint,
                   got_at_target);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got_setpoint !== want.setpoint) begin
            $error("setpoint: expected %h, actual %h", want.setpoint, got_setpoint);
            mismatches++;
         end
         if (got_at_target !== want.at_target) begin
            $error("at_target: expected %b, actual %b", want.at_target, got_at_target);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic               req_operation = 1'b0;
   logic signed [31:0] req_target_value = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire signed [31:0]  rsp_setpoint;
   wire                rsp_at_target;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   wire [31:0]         csr_prdata;
   wire                csr_pready;

   ramp_tracker sb;

   // Requests still to go in the current sender burst.
   int             burst_left = 0;
   stall_kind_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   bit             stall_toggle = 1'b0;

   setpoint_ramp_generator_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_target_value(req_target_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_setpoint    (rsp_setpoint),
      .rsp_at_target   (rsp_at_target),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver changes its stall pattern after each random stretch, so stalls land on every
   // phase of the block's work, and some stretches never stall at all.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      stall_toggle = ~stall_toggle;
      case (stall_mode)
         STALL_NONE:      rsp_ready <= 1'b1;
         STALL_RANDOM:    rsp_ready <= 1'($urandom_range(0, 1));
         STALL_ALTERNATE: rsp_ready <= stall_toggle;
         default:         rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Responses are taken at the rising edge, before the block's registers update.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_setpoint, rsp_at_target);
   end

   // Presents one request and returns once it has been accepted. The sender works in bursts;
   // between bursts valid drops for a random gap, and some bursts follow with no gap at all.
   // Within a burst valid stays high from one request to the next.
   task automatic send_request(input srg_pkg::op_type op, input logic [31:0] value);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_target_value <= value;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(op, value);
   endtask

   // Stops the sender and waits until every expected response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A register write: a setup phase, then the access phase until pready.
   task automatic write_register(input srg_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      sb.apply_register(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Step and scale values: zero, the largest value, small values, anything, and one.
   function automatic logic [30:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 31'h7FFF_FFFF;
         2, 3:    return 31'($urandom_range(1, 32'h0004_0000));
         4:       return 31'($urandom());
         default: return 31'h0001_0000;
      endcase
   endfunction

   // Targets are often placed near the current setpoint or near the exponential magnitude so
   // that ramps actually arrive; the rest are anywhere, or at the ends of the range.
   function automatic logic [31:0] pick_target();
      logic [31:0] offset;
      offset = $urandom() >> $urandom_range(7, 31);
      case ($urandom_range(0, 5))
         0, 1:    return $urandom();
         2:       return sb.setpoint + offset;
         3:       return sb.setpoint - offset;
         4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 1) ? {1'b0, sb.exp_gain} + offset
                                              : -({1'b0, sb.exp_gain} + offset);
      endcase
   endfunction

   // New register settings for one random phase. The unused upper bits of each write carry
   // random junk, which the block must ignore.
   task automatic configure_phase(input int phase);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom();
      write_register(srg_pkg::REG_RAMP_ENABLE, {junk[31:1], 1'(phase % 5 != 4)});
      junk = $urandom();
      write_register(srg_pkg::REG_RAMP_MODE, {junk[31:1], phase[0]});
      write_register(srg_pkg::REG_RAMP_STEP, {junk[31], pick_rate()});
      write_register(srg_pkg::REG_EXP_SCALE, {junk[30], pick_rate()});
   endtask

   initial begin
      int sent;
      int style;
      int ticks;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset settings: linear mode with a step of one.
      // A tick while already at the target leaves everything alone.
      send_request(srg_pkg::OP_TICK, 32'h1234_5678);
      // Ramp up to 3.5 in steps of one, the last step clamped onto the target.
      send_request(srg_pkg::OP_SET_TARGET, 32'h0003_8000);
      repeat (4) send_request(srg_pkg::OP_TICK, '0);
      // Largest step, with bit 31 of the write set: down to the most negative target.
      send_request(srg_pkg::OP_SET_TARGET, 32'h8000_0000);
      wait_drained();
      write_register(srg_pkg::REG_RAMP_STEP, 32'hFFFF_FFFF);
      repeat (2) send_request(srg_pkg::OP_TICK, 32'hFFFF_FFFF);
      // And back up to the most positive target.
      send_request(srg_pkg::OP_SET_TARGET, 32'h7FFF_FFFF);
      repeat (3) send_request(srg_pkg::OP_TICK, '0);
      // A zero step never moves the setpoint.
      wait_drained();
      write_register(srg_pkg::REG_RAMP_STEP, '0);
      send_request(srg_pkg::OP_SET_TARGET, '0);
      send_request(srg_pkg::OP_TICK, '0);
      // Exponential mode with the largest scale: the magnitude saturates both ways. Down to
      // zero it overshoots and clamps; up and down to the range ends it hits exactly.
      wait_drained();
      write_register(srg_pkg::REG_RAMP_MODE, 32'h0000_0001);
      write_register(srg_pkg::REG_EXP_SCALE, 32'h7FFF_FFFF);
      send_request(srg_pkg::OP_TICK, '0);
      send_request(srg_pkg::OP_SET_TARGET, 32'h7FFF_FFFF);
      send_request(srg_pkg::OP_TICK, '0);
      send_request(srg_pkg::OP_SET_TARGET, 32'h8000_0000);
      send_request(srg_pkg::OP_TICK, '0);
      // Scale of one: the grown factor lands just past a target slightly above one.
      wait_drained();
      write_register(srg_pkg::REG_EXP_SCALE, 32'h0001_0000);
      send_request(srg_pkg::OP_SET_TARGET, 32'h0001_0050);
      send_request(srg_pkg::OP_TICK, '0);
      // With the ramp off, a new target moves the setpoint straight there.
      wait_drained();
      write_register(srg_pkg::REG_RAMP_ENABLE, '0);
      send_request(srg_pkg::OP_SET_TARGET, 32'h0032_0000);
      // Ramp back on: from 50 toward 100 the exponential value drops to about one, farther
      // from the target, and is kept.
      wait_drained();
      write_register(srg_pkg::REG_RAMP_ENABLE, 32'h0000_0001);
      send_request(srg_pkg::OP_SET_TARGET, 32'h0064_0000);
      send_request(srg_pkg::OP_TICK, '0);
      // The sender holds off here until every response is back.
      wait_drained();
      send_request(srg_pkg::OP_TICK, '0);

      // Long exponential climb with a tiny scale toward an unreachable target, so that the
      // growth factor keeps compounding over many ticks without ever clamping.
      wait_drained();
      write_register(srg_pkg::REG_EXP_SCALE, 32'h0000_0001);
      send_request(srg_pkg::OP_SET_TARGET, 32'h7FFF_FFFF);
      repeat (300) send_request(srg_pkg::OP_TICK, $urandom());

      // Random phases. Most of the traffic is a new target followed by a run of ticks; the
      // rest is loose requests and an occasional full drain before the next request.
      for (int phase = 0; phase < 8; phase++) begin
         configure_phase(phase);
         sent = 0;
         while (sent < 105) begin
            style = $urandom_range(0, 9);
            if (style < 7) begin
               send_request(srg_pkg::OP_SET_TARGET, pick_target());
               ticks = $urandom_range(1, 40);
               repeat (ticks) send_request(srg_pkg::OP_TICK, $urandom());
               sent += ticks + 1;
            end else if (style < 9) begin
               send_request(srg_pkg::op_type'($urandom_range(0, 1)), $urandom());
               sent++;
            end else begin
               wait_drained();
               send_request(srg_pkg::OP_TICK, $urandom());
               sent++;
            end
         end
      end

      // Let the last responses drain, then allow a little longer for anything stray.
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASS setpoint_ramp_generator_top");
      else
         $display("FAIL setpoint_ramp_generator_top");
      $finish;
   end

   // Watchdog: a correct run finishes far earlier than this.
   initial begin
      #20000000;
      $display("FAIL setpoint_ramp_generator_top");
      $finish;
   end

endmodule

/* sim.f */
rtl/srg_pkg.sv
rtl/setpoint_ramp_generator_top.sv
verif/setpoint_ramp_generator_top_test.sv
